// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/mcpa_pkg.sv =====
// ----------------------------------------------------------------------------
// mcpa_pkg
// codes and widths shared by the primitive assembler and its channels
// ----------------------------------------------------------------------------
package mcpa_pkg;

    localparam int PORT_INDEX_W = 32;
    localparam int POS_W        = 3;
    localparam logic [POS_W-1:0] POS_MAX = 3'd7;

    typedef enum logic [1:0] {
        CELL_POLYGON  = 2'd0,
        CELL_STRIP    = 2'd1,
        CELL_POLYLINE = 2'd2,
        CELL_VERTEX   = 2'd3
    } t_cell_kind;

    typedef enum logic [1:0] {
        PRIM_TRIANGLE = 2'd0,
        PRIM_LINE     = 2'd1,
        PRIM_POINT    = 2'd2
    } t_prim_kind;

endpackage

// ===== sv/mcpa_cell_if.sv =====
// ----------------------------------------------------------------------------
// mcpa_cell_if
// cell index channel: one vertex index per request
// ----------------------------------------------------------------------------
interface mcpa_cell_if import mcpa_pkg::*; ();
    logic                    valid;
    logic                    ready;
    t_cell_kind              cell_kind;
    logic [PORT_INDEX_W-1:0] vertex_index;
    logic                    last_in_cell;

    modport source (output valid, cell_kind, vertex_index, last_in_cell, input ready);
    modport sink   (input valid, cell_kind, vertex_index, last_in_cell, output ready);
endinterface

// ===== sv/mcpa_prim_if.sv =====
// ----------------------------------------------------------------------------
// mcpa_prim_if
// primitive channel: one index primitive per request
// ----------------------------------------------------------------------------
interface mcpa_prim_if import mcpa_pkg::*; ();
    logic                    valid;
    logic                    ready;
    t_prim_kind              prim_kind;
    logic [PORT_INDEX_W-1:0] corner_a;
    logic [PORT_INDEX_W-1:0] corner_b;
    logic [PORT_INDEX_W-1:0] corner_c;
    logic                    last_of_run;

    modport source (output valid, prim_kind, corner_a, corner_b, corner_c, last_of_run,
                    input ready);
    modport sink   (input valid, prim_kind, corner_a, corner_b, corner_c, last_of_run,
                    output ready);
endinterface

// ===== sv/mesh_cell_to_primitive_assembler_core.sv =====
// ----------------------------------------------------------------------------
// mesh_cell_to_primitive_assembler_core
// turns a stream of cell vertex indices into triangles, segments and points
// ----------------------------------------------------------------------------
// One vertex index is taken per cycle while the result queue holds at most
// one entry, and its primitives are formed in the same cycle from the cell
// history registers, then written into a three-entry result queue that drives
// the output. Input ready depends only on the queue fill, so there is no
// combinational path from output ready to input ready. A closing four-vertex
// polygon puts two primitives into the queue at once, which leaves at least
// two entries queued and holds input ready low until the output has drained
// the queue to one entry. Output stalls hold the input once the queue has
// more than one entry. Primitives reach the output through the registered
// result queue.
`include "assert_macros.svh"

module mesh_cell_to_primitive_assembler_core import mcpa_pkg::*; #(
    parameter int INDEX_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcpa_cell_if.sink   i_cell,
    mcpa_prim_if.source o_prim
);

    localparam int IW = INDEX_WIDTH;

    typedef struct packed {
        t_prim_kind    kind;
        logic [IW-1:0] a;
        logic [IW-1:0] b;
        logic [IW-1:0] c;
        logic          last;
    } t_prim_q;

    logic [IW-1:0]    r_head [3];
    logic [IW-1:0]    r_pair [2];
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_odd, n_odd;
    t_prim_q          r_q [3];
    t_prim_q          n_q [3];
    logic [1:0]       r_cnt, n_cnt;

    logic          push, pop;
    logic [IW-1:0] v;
    logic [1:0]    new_cnt, base;
    t_prim_q       p0, p1;

    assign v    = i_cell.vertex_index[IW-1:0];
    assign push = i_cell.valid && i_cell.ready;
    assign pop  = o_prim.valid && o_prim.ready;

    // primitive forming
    always_comb begin
        new_cnt = 2'd0;
        p0      = '{kind: PRIM_TRIANGLE, a: '0, b: '0, c: '0, last: 1'b1};
        p1      = '{kind: PRIM_TRIANGLE, a: '0, b: '0, c: '0, last: 1'b1};
        unique case (i_cell.cell_kind)
            CELL_POLYGON: begin
                if (i_cell.last_in_cell && r_pos == 3'd2) begin
                    new_cnt = 2'd1;
                    p0.a    = r_head[0];
                    p0.b    = r_head[1];
                    p0.c    = v;
                end else if (i_cell.last_in_cell && r_pos == 3'd3) begin
                    new_cnt = 2'd2;
                    p0.a    = r_head[0];
                    p0.b    = r_head[1];
                    p0.c    = r_head[2];
                    p0.last = 1'b0;
                    p1.a    = v;
                    p1.b    = r_head[0];
                    p1.c    = r_head[2];
                end
            end
            CELL_STRIP: begin
                if (r_pos >= 3'd2) begin
                    new_cnt = 2'd1;
                    p0.a    = r_odd ? r_pair[1] : r_pair[0];
                    p0.b    = r_odd ? r_pair[0] : r_pair[1];
                    p0.c    = v;
                end
            end
            CELL_POLYLINE: begin
                if (r_pos >= 3'd1) begin
                    new_cnt = 2'd1;
                    p0.kind = PRIM_LINE;
                    p0.a    = r_pair[1];
                    p0.b    = v;
                end
            end
            CELL_VERTEX: begin
                if (r_pos == 3'd0) begin
                    new_cnt = 2'd1;
                    p0.kind = PRIM_POINT;
                    p0.a    = v;
                end
            end
            default: ;
        endcase
    end

    // result queue, head at entry zero
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            n_q[i] = pop ? r_q[i+1] : r_q[i];
        end
        n_q[2] = r_q[2];
        base  = r_cnt - {1'b0, pop};
        n_cnt = base;
        if (push && new_cnt != 2'd0) begin
            n_q[base] = p0;
            if (new_cnt == 2'd2) begin
                n_q[2'(base + 2'd1)] = p1;
            end
            n_cnt = base + new_cnt;
        end
    end

    always_comb begin
        if (i_cell.last_in_cell) begin
            n_pos = '0;
            n_odd = 1'b0;
        end else begin
            n_pos = (r_pos < POS_MAX) ? r_pos + 3'd1 : POS_MAX;
            n_odd = ~r_odd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_pos  <= '0;
            r_odd  <= 1'b0;
            r_head <= '{default: '0};
            r_pair <= '{default: '0};
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_pos     <= n_pos;
                r_odd     <= n_odd;
                r_pair[0] <= r_pair[1];
                r_pair[1] <= v;
                if (r_pos < 3'd3) begin
                    r_head[r_pos[1:0]] <= v;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign i_cell.ready       = (r_cnt <= 2'd1);
    assign o_prim.valid       = (r_cnt != 2'd0);
    assign o_prim.prim_kind   = r_q[0].kind;
    assign o_prim.corner_a    = PORT_INDEX_W'(r_q[0].a);
    assign o_prim.corner_b    = PORT_INDEX_W'(r_q[0].b);
    assign o_prim.corner_c    = PORT_INDEX_W'(r_q[0].c);
    assign o_prim.last_of_run = r_q[0].last;

    // quad close always leaves at least two primitives queued
    `ASSERT_NXT(a_quad_queued, i_clk, i_rst_n, push && i_cell.cell_kind == CELL_POLYGON && i_cell.last_in_cell && r_pos == 3'd3, r_cnt >= 2'd2)
    // end of cell rewinds position and parity
    `ASSERT_NXT(a_cell_rewind, i_clk, i_rst_n, push && i_cell.last_in_cell, r_pos == 3'd0 && !r_odd)
    // points carry no second or third corner
    `ASSERT_IMP(a_point_clean, i_clk, i_rst_n, o_prim.valid && o_prim.prim_kind == PRIM_POINT, o_prim.corner_b == '0 && o_prim.corner_c == '0)

endmodule
